@@ design/sll_pkg.sv @@
// shared types, constants and helpers for the static linked list engine
package sll_pkg;

    localparam int SLOTS  = 1024;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int POS_W  = 10;
    localparam int LEN_W  = 10;
    localparam int VAL_W  = 32;

    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [POS_W-1:0]        pos_t;
    typedef logic [LEN_W-1:0]        len_t;
    typedef logic signed [VAL_W-1:0] value_t;

    localparam addr_t FREE_HEAD = '0;
    localparam addr_t LIST_HEAD = addr_t'(SLOTS - 1);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_POS = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_FREE,
        S_POP,
        S_WALK,
        S_LINK,
        S_DEL_RD,
        S_DEL_FREE,
        S_DEL_HEAD,
        S_DONE
    } state_t;

    // a link that names no slot reads as the free head
    function automatic addr_t slot_of(addr_t x);
        return ({1'b0, x} < (ADDR_W + 1)'(SLOTS)) ? x : FREE_HEAD;
    endfunction

endpackage

@@ design/sll_if.sv @@
// request and response channel interfaces of the static linked list engine
interface sll_req_if;
    import sll_pkg::*;

    logic   valid;
    logic   ready;
    logic   cmd;
    pos_t   position;
    value_t value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink (input valid, input cmd, input position, input value, output ready);
endinterface

interface sll_rsp_if;
    import sll_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] status;
    len_t       length;

    modport source (output valid, output status, output length, input ready);
    modport sink (input valid, input status, input length, output ready);
endinterface

@@ design/static_linked_list_engine.sv @@
// static linked list engine: sequencer walking the link store one hop per cycle
// sequence: a rejected word goes straight to the done state, an insert into a full store
//   ends after the free head read; an insert or a delete at position p walks to the slot before p
// a new word is accepted only in the idle state, once the last result has gone to the output register
// reset: a clearing pass over all SLOTS (1024) slots builds the free chain; no word
//   is accepted until it ends
module static_linked_list_engine (
    input  logic      clk,
    input  logic      rst_n,
    sll_req_if.sink   req,
    sll_rsp_if.source rsp
);
    import sll_pkg::*;

    state_t  state_reg,  state_next;
    addr_t   init_reg,   init_next;
    logic    cmd_reg,    cmd_next;
    value_t  val_reg,    val_next;
    pos_t    left_reg,   left_next;
    addr_t   node_reg,   node_next;
    addr_t   fresh_reg,  fresh_next;
    status_t status_reg, status_next;
    len_t    count_reg,  count_next;

    logic    out_valid_reg;
    status_t out_status_reg;
    len_t    out_length_reg;
    logic    out_load;

    logic    lnk_we;
    addr_t   lnk_wa;
    addr_t   lnk_wd;
    addr_t   lnk_ra;
    addr_t   lnk_rd;
    addr_t   rd_slot;
    logic    val_we;

    logic    ins_bad;
    logic    del_bad;
    logic    req_bad;
    logic    out_free;

    sll_link_ram u_link (
        .clk     (clk),
        .wr_en   (lnk_we),
        .wr_addr (lnk_wa),
        .wr_data (lnk_wd),
        .rd_addr (lnk_ra),
        .rd_data (lnk_rd)
    );

    sll_value_ram u_value (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (fresh_reg),
        .wr_data (val_reg)
    );

    assign rd_slot  = slot_of(lnk_rd);
    assign ins_bad  = (req.position == '0) ||
                      ({1'b0, req.position} > ({1'b0, count_reg} + (LEN_W + 1)'(1)));
    assign del_bad  = (req.position == '0) || (req.position > count_reg);
    assign req_bad  = (req.cmd == CMD_INSERT) ? ins_bad : del_bad;
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.length = out_length_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (init_reg == LIST_HEAD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req_bad)
                    begin
                        state_next = S_DONE;
                    end
                    else if (req.cmd == CMD_INSERT)
                    begin
                        state_next = S_FREE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_FREE:     state_next = (rd_slot == FREE_HEAD) ? S_DONE : S_POP;
            S_POP:      state_next = S_WALK;
            S_WALK:
            begin
                if (left_reg == '0)
                begin
                    state_next = (cmd_reg == CMD_INSERT) ? S_LINK : S_DEL_RD;
                end
            end
            S_LINK:     state_next = S_DONE;
            S_DEL_RD:   state_next = S_DEL_FREE;
            S_DEL_FREE: state_next = S_DEL_HEAD;
            S_DEL_HEAD: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_INIT;
        endcase
    end

    // datapath and store control
    always_comb
    begin
        init_next   = init_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        left_next   = left_reg;
        node_next   = node_reg;
        fresh_next  = fresh_reg;
        status_next = status_reg;
        count_next  = count_reg;
        lnk_we      = 1'b0;
        lnk_wa      = FREE_HEAD;
        lnk_wd      = FREE_HEAD;
        lnk_ra      = FREE_HEAD;
        val_we      = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                lnk_we    = 1'b1;
                lnk_wa    = init_reg;
                lnk_wd    = (init_reg == addr_t'(SLOTS - 2) || init_reg == LIST_HEAD) ?
                            FREE_HEAD : addr_t'(init_reg + 1'b1);
                init_next = addr_t'(init_reg + 1'b1);
            end
            S_IDLE:
            begin
                cmd_next    = req.cmd;
                val_next    = req.value;
                left_next   = pos_t'(req.position - 1'b1);
                node_next   = LIST_HEAD;
                status_next = req_bad ? STAT_BAD_POS : STAT_OK;
                lnk_ra      = (req.cmd == CMD_INSERT) ? FREE_HEAD : LIST_HEAD;
            end
            S_FREE:
            begin
                // head of the free chain is the node to fill
                fresh_next = rd_slot;
                lnk_ra     = rd_slot;
                if (rd_slot == FREE_HEAD)
                begin
                    status_next = STAT_FULL;
                end
            end
            S_POP:
            begin
                lnk_we    = 1'b1;
                lnk_wa    = FREE_HEAD;
                lnk_wd    = rd_slot;
                val_we    = 1'b1;
                lnk_ra    = LIST_HEAD;
                node_next = LIST_HEAD;
            end
            S_WALK:
            begin
                if (left_reg != '0)
                begin
                    // one hop per cycle, read address straight from the read data
                    lnk_ra    = rd_slot;
                    node_next = rd_slot;
                    left_next = pos_t'(left_reg - 1'b1);
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    lnk_we = 1'b1;
                    lnk_wa = fresh_reg;
                    lnk_wd = rd_slot;
                end
                else
                begin
                    // node being removed
                    fresh_next = rd_slot;
                    lnk_ra     = rd_slot;
                end
            end
            S_LINK:
            begin
                lnk_we     = 1'b1;
                lnk_wa     = node_reg;
                lnk_wd     = fresh_reg;
                count_next = len_t'(count_reg + 1'b1);
            end
            S_DEL_RD:
            begin
                lnk_we = 1'b1;
                lnk_wa = node_reg;
                lnk_wd = rd_slot;
                lnk_ra = FREE_HEAD;
            end
            S_DEL_FREE:
            begin
                lnk_we = 1'b1;
                lnk_wa = fresh_reg;
                lnk_wd = rd_slot;
            end
            S_DEL_HEAD:
            begin
                lnk_we     = 1'b1;
                lnk_wa     = FREE_HEAD;
                lnk_wd     = fresh_reg;
                count_next = len_t'(count_reg - 1'b1);
            end
            S_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        left_reg   <= left_next;
        node_reg   <= node_next;
        fresh_reg  <= fresh_next;
        status_reg <= status_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_length_reg <= count_reg;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= len_t'(SLOTS - 2))
        else $error("element count above store capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == S_LINK || $past(state_reg) == S_DEL_HEAD))
        else $error("element count changed outside a link update");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("response raised without a finished operation");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE && state_reg != S_INIT))
        else $error("sequencer idle right after accepting a word");
endmodule

@@ design/sll_link_ram.sv @@
// link store: one write port and one registered read port
module sll_link_ram (
    input  logic           clk,
    input  logic           wr_en,
    input  sll_pkg::addr_t wr_addr,
    input  sll_pkg::addr_t wr_data,
    input  sll_pkg::addr_t rd_addr,
    output sll_pkg::addr_t rd_data
);
    import sll_pkg::*;

    addr_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ design/sll_value_ram.sv @@
// value store: element values written on insert
module sll_value_ram (
    input  logic            clk,
    input  logic            wr_en,
    input  sll_pkg::addr_t  wr_addr,
    input  sll_pkg::value_t wr_data
);
    import sll_pkg::*;

    value_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end
endmodule

@@ dv/tb.sv @@
// testbench for static_linked_list_engine: directed table, then predictor-checked traffic
`timescale 1ns / 1ps

module tb;
    import sll_pkg::*;

    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_WORDS  = 110;
    localparam int GROW_OPS     = 40;
    localparam int CHURN_OPS    = 60;
    localparam int SETTLE_CYCLES = 1100;

    typedef struct packed {
        status_t status;
        len_t    len;
    } list_result_t;

    typedef struct {
        cmd_t    cmd;
        pos_t    position;
        value_t  value;
        bit      typed;
        status_t want_status;
        len_t    want_len;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sll_req_if req_ch();
    sll_rsp_if rsp_ch();

    static_linked_list_engine uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // list model: links only, the stored values never show up in a result
    addr_t next_slot [SLOTS];
    int    list_len;

    list_result_t pending_results [$];

    int  mismatches     = 0;
    int  words_sent     = 0;
    int  results_checked = 0;
    int  bad_pos_seen   = 0;
    int  full_seen      = 0;
    int  longest_list   = 0;
    int  gap_pct        = 0;
    int  stall_pct      = 0;
    bit  hold_go        = 1'b0;

    stim_row_t directed_rows [21] = '{
        '{CMD_DELETE, 10'd1,    32'sd0,         1'b1, STAT_BAD_POS, 10'd0},
        '{CMD_DELETE, 10'd0,    32'sd0,         1'b1, STAT_BAD_POS, 10'd0},
        '{CMD_INSERT, 10'd0,    32'sd5,         1'b1, STAT_BAD_POS, 10'd0},
        '{CMD_INSERT, 10'd2,    32'sd7,         1'b1, STAT_BAD_POS, 10'd0},
        '{CMD_INSERT, 10'd1023, -32'sd1,        1'b1, STAT_BAD_POS, 10'd0},
        '{CMD_INSERT, 10'd1,    32'h7fff_ffff,  1'b1, STAT_OK,      10'd1},
        '{CMD_INSERT, 10'd1,    32'h8000_0000,  1'b1, STAT_OK,      10'd2},
        '{CMD_INSERT, 10'd3,    32'sd0,         1'b1, STAT_OK,      10'd3},
        '{CMD_INSERT, 10'd2,    -32'sd1,        1'b1, STAT_OK,      10'd4},
        '{CMD_INSERT, 10'd6,    32'sd9,         1'b1, STAT_BAD_POS, 10'd4},
        '{CMD_DELETE, 10'd5,    32'sd0,         1'b1, STAT_BAD_POS, 10'd4},
        '{CMD_DELETE, 10'd4,    -32'sd1,        1'b1, STAT_OK,      10'd3},
        '{CMD_DELETE, 10'd2,    32'sd0,         1'b1, STAT_OK,      10'd2},
        '{CMD_INSERT, 10'd2,    32'h5a5a_5a5a,  1'b0, STAT_OK,      10'd0},
        '{CMD_INSERT, 10'd4,    32'ha5a5_a5a5,  1'b0, STAT_OK,      10'd0},
        '{CMD_DELETE, 10'd1,    32'sd0,         1'b0, STAT_OK,      10'd0},
        '{CMD_DELETE, 10'd1023, 32'sd0,         1'b1, STAT_BAD_POS, 10'd3},
        '{CMD_DELETE, 10'd3,    32'sd0,         1'b0, STAT_OK,      10'd0},
        '{CMD_DELETE, 10'd1,    32'sd0,         1'b1, STAT_OK,      10'd1},
        '{CMD_DELETE, 10'd1,    32'sd0,         1'b1, STAT_OK,      10'd0},
        '{CMD_DELETE, 10'd1,    32'sd0,         1'b1, STAT_BAD_POS, 10'd0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic clear_list_model;
        for (int n = 0; n < SLOTS; n++)
        begin
            next_slot[n] = addr_t'(n + 1);
        end
        next_slot[SLOTS-2] = FREE_HEAD;
        next_slot[LIST_HEAD] = FREE_HEAD;
        list_len = 0;
    endtask

    // slot whose link names the element at 1-based position p
    function automatic addr_t slot_before(pos_t p);
        addr_t node;
        node = LIST_HEAD;
        for (int hop = 1; hop < int'(p); hop++)
        begin
            node = next_slot[node];
        end
        return node;
    endfunction

    function automatic list_result_t apply_list_op(cmd_t c, pos_t p);
        list_result_t res;
        addr_t prev;
        addr_t spare;
        addr_t gone;
        res.status = STAT_OK;
        if (c == CMD_INSERT)
        begin
            if (p == 0 || int'(p) > list_len + 1)
            begin
                res.status = STAT_BAD_POS;
            end
            else if (next_slot[FREE_HEAD] == FREE_HEAD)
            begin
                res.status = STAT_FULL;
            end
            else
            begin
                spare = next_slot[FREE_HEAD];
                next_slot[FREE_HEAD] = next_slot[spare];
                prev = slot_before(p);
                next_slot[spare] = next_slot[prev];
                next_slot[prev] = spare;
                list_len++;
            end
        end
        else
        begin
            if (p == 0 || int'(p) > list_len)
            begin
                res.status = STAT_BAD_POS;
            end
            else
            begin
                prev = slot_before(p);
                gone = next_slot[prev];
                next_slot[prev] = next_slot[gone];
                next_slot[gone] = next_slot[FREE_HEAD];
                next_slot[FREE_HEAD] = gone;
                list_len--;
            end
        end
        res.len = len_t'(list_len);
        return res;
    endfunction

    // offer one word, wait for its handshake, then record what it should produce
    task automatic issue(cmd_t c, pos_t p, value_t v, bit typed = 1'b0,
                         status_t want_status = STAT_OK, len_t want_len = '0);
        list_result_t predicted;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= c;
        req_ch.position <= p;
        req_ch.value    <= v;
        do @(posedge clk); while (!req_ch.ready);
        predicted = apply_list_op(c, p);
        words_sent++;
        if (predicted.status == STAT_BAD_POS)
            bad_pos_seen++;
        if (predicted.status == STAT_FULL)
            full_seen++;
        if (list_len > longest_list)
            longest_list = list_len;
        if (typed)
        begin
            predicted.status = want_status;
            predicted.len    = want_len;
        end
        pending_results.push_back(predicted);
    endtask

    // mostly well-formed operations inside the list, some off the ends
    task automatic pick_list_op(output cmd_t c, output pos_t p);
        int r;
        int top;
        r = $urandom_range(99);
        if (r < 12)
        begin
            c = cmd_t'($urandom_range(1));
            case ($urandom_range(2))
                0: p = pos_t'($urandom_range(1023));
                1: p = '0;
                default: p = pos_t'(list_len + ((c == CMD_INSERT) ? 2 : 1));
            endcase
        end
        else
        begin
            c = (r < 62 || list_len == 0) ? CMD_INSERT : CMD_DELETE;
            top = (c == CMD_INSERT) ? list_len + 1 : list_len;
            if ($urandom_range(3) == 0)
                p = pos_t'($urandom_range(1) ? 1 : top);
            else
                p = pos_t'($urandom_range(top, 1));
        end
    endtask

    task automatic drain_results;
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic set_idling(int gap, int stall);
        gap_pct = gap;
        stall_pct <= stall;
    endtask

    task automatic check_result(logic [1:0] st, len_t ln);
        list_result_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: result with nothing pending: status %0d length %0d", $time, st, ln);
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            results_checked++;
            if (st !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, st);
                mismatches++;
            end
            if (ln !== want.len)
            begin
                $display("%0t: length mismatch: expected %0d, actual %0d",
                         $time, want.len, ln);
                mismatches++;
            end
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                check_result(rsp_ch.status, rsp_ch.length);
            if (hold_go)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
            end
        end
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results still pending",
                 $time, CYCLE_LIMIT, pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int gap_mix [4];
        int stall_mix [4];
        cmd_t c;
        pos_t p;
        gap_mix   = '{0, 51, 0, 35};
        stall_mix = '{0, 0, 51, 35};
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.cmd      <= CMD_INSERT;
        req_ch.position <= '0;
        req_ch.value    <= '0;
        clear_list_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // clearing pass after reset: the first handshake simply waits for it
        foreach (directed_rows[i])
        begin
            issue(directed_rows[i].cmd, directed_rows[i].position, directed_rows[i].value,
                  directed_rows[i].typed, directed_rows[i].want_status,
                  directed_rows[i].want_len);
        end
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            set_idling(gap_mix[ph], stall_mix[ph]);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                pick_list_op(c, p);
                issue(c, p, value_t'($urandom()));
            end
            drain_results();
        end

        // long result hold-off while words keep coming, so the input backs up
        set_idling(0, 0);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        for (int k = 0; k < 14; k++)
        begin
            pick_list_op(c, p);
            issue(c, p, value_t'($urandom()));
        end
        drain_results();

        // grow the list, mostly near the head to keep the walks short
        set_idling(35, 35);
        for (int k = 0; k < GROW_OPS; k++)
        begin
            if ($urandom_range(3) == 0)
                p = pos_t'($urandom_range(list_len + 1, 1));
            else
                p = pos_t'($urandom_range((list_len < 8) ? list_len + 1 : 8, 1));
            issue(CMD_INSERT, p, value_t'($urandom()));
        end
        issue(CMD_INSERT, pos_t'(list_len + 1), value_t'($urandom()));
        issue(CMD_INSERT, 10'd1, value_t'($urandom()));
        issue(CMD_INSERT, 10'd0, value_t'($urandom()));
        issue(CMD_DELETE, 10'd1023, value_t'($urandom()));
        issue(CMD_DELETE, pos_t'(list_len), value_t'($urandom()));
        issue(CMD_INSERT, 10'd1023, value_t'($urandom()));

        // churn on the longer list: long walks and freed slots reused
        set_idling(0, 0);
        for (int k = 0; k < CHURN_OPS; k++)
        begin
            pick_list_op(c, p);
            issue(c, p, value_t'($urandom()));
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d words, %0d results checked, longest list %0d",
                 words_sent, results_checked, longest_list);
        $display("rejections seen: %0d bad position, %0d store full",
                 bad_pos_seen, full_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
